// File: rtl/lsmt_pkg.sv
// Shared types and constants for the locked sorted mark table.
// Used by every module of the block except lsmt_ram; depends on nothing.
`timescale 1ns / 1ps

package lsmt_pkg;

    // Table geometry
    localparam int MAX_MARKS = 256;
    localparam int ADDR_W    = $clog2(MAX_MARKS);
    localparam int CNT_W     = $clog2(MAX_MARKS + 1);

    // Field widths
    localparam int CMD_W     = 3;
    localparam int ST_W      = 3;
    localparam int IDX_W     = 16;
    localparam int POS_W     = 32;
    localparam int CONF_W    = 17;
    localparam int WORD_W    = POS_W + CONF_W + 1;
    localparam int CFG_IDX_W = 2;

    // Word layout in the table memory: {lock, confidence, position}
    localparam int W_CONF_LO = POS_W;
    localparam int W_LOCK    = POS_W + CONF_W;

    localparam logic [CONF_W-1:0] CONF_ONE = CONF_W'(65536);
    localparam logic [CNT_W-1:0]  MIN_KEEP = CNT_W'(3);

    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_ADD    = 3'd0;
    localparam cmd_t CMD_MOVE   = 3'd1;
    localparam cmd_t CMD_REMOVE = 3'd2;
    localparam cmd_t CMD_LOCK   = 3'd3;
    localparam cmd_t CMD_READ   = 3'd4;

    typedef logic [ST_W-1:0] st_t;
    localparam st_t ST_OK        = 3'd0;
    localparam st_t ST_INVALID   = 3'd1;
    localparam st_t ST_NOT_FOUND = 3'd2;
    localparam st_t ST_CONFLICT  = 3'd3;
    localparam st_t ST_INVARIANT = 3'd4;
    localparam st_t ST_FULL      = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ENTRY,
        S_SCAN,
        S_EVAL,
        S_SHIFT,
        S_PLACE,
        S_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic fetch;
        logic scan_start;
        logic shift_start;
        logic step;
        logic wr_lock;
        logic wr_place;
        logic cnt_inc;
        logic cnt_dec;
        logic keep_read;
        logic load_out;
        st_t  status;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic idx_bad;
        logic conf_bad;
        logic full;
        logic at_min;
        logic locked;
        logic eng_done;
        logic pipe_busy;
        logic dup;
        logic rng_bad;
        logic range_inv;
        logic new_out;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/lsmt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module lsmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lsmt_ctrl.sv
// Command sequencer for the mark table: decode, checks, scan, shift, reply.
// Depends on lsmt_pkg.
`timescale 1ns / 1ps

module lsmt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  lsmt_pkg::dp_stat_t stat,
    output lsmt_pkg::ctrl_cmd_t cmd
);

    lsmt_pkg::state_t state_reg, state_next;
    lsmt_pkg::st_t    status_reg, status_next;

    // State and pending status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= lsmt_pkg::S_IDLE;
            status_reg <= lsmt_pkg::ST_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        s_tready    = 1'b0;
        unique case (state_reg)
            lsmt_pkg::S_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid) begin
                    state_next = lsmt_pkg::S_DECODE;
                end
            end
            lsmt_pkg::S_DECODE: begin
                state_next = lsmt_pkg::S_FINISH;
                if (stat.cmd == lsmt_pkg::CMD_ADD) begin
                    if (stat.conf_bad) begin
                        status_next = lsmt_pkg::ST_INVALID;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = lsmt_pkg::S_SCAN;
                    end
                end else if (stat.cmd == lsmt_pkg::CMD_MOVE || stat.cmd == lsmt_pkg::CMD_REMOVE
                             || stat.cmd == lsmt_pkg::CMD_LOCK
                             || stat.cmd == lsmt_pkg::CMD_READ) begin
                    if (stat.idx_bad) begin
                        status_next = lsmt_pkg::ST_NOT_FOUND;
                    end else begin
                        cmd.fetch  = 1'b1;
                        state_next = lsmt_pkg::S_ENTRY;
                    end
                end else begin
                    status_next = lsmt_pkg::ST_INVALID;
                end
            end
            lsmt_pkg::S_ENTRY: begin
                state_next  = lsmt_pkg::S_FINISH;
                status_next = lsmt_pkg::ST_OK;
                if (stat.cmd == lsmt_pkg::CMD_READ) begin
                    cmd.keep_read = 1'b1;
                end else if (stat.cmd == lsmt_pkg::CMD_LOCK) begin
                    cmd.wr_lock = 1'b1;
                end else if (stat.locked ||
                             (stat.cmd == lsmt_pkg::CMD_REMOVE && stat.at_min)) begin
                    status_next = lsmt_pkg::ST_CONFLICT;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = lsmt_pkg::S_SCAN;
                end
            end
            lsmt_pkg::S_SCAN: begin
                cmd.step = !stat.eng_done;
                if (stat.eng_done && !stat.pipe_busy) begin
                    state_next = lsmt_pkg::S_EVAL;
                end
            end
            lsmt_pkg::S_EVAL: begin
                state_next = lsmt_pkg::S_FINISH;
                priority if (stat.cmd == lsmt_pkg::CMD_ADD && stat.dup) begin
                    status_next = lsmt_pkg::ST_CONFLICT;
                end else if (stat.cmd == lsmt_pkg::CMD_ADD && stat.full) begin
                    status_next = lsmt_pkg::ST_FULL;
                end else if (stat.range_inv) begin
                    status_next = lsmt_pkg::ST_INVALID;
                end else if (stat.rng_bad || (stat.cmd != lsmt_pkg::CMD_REMOVE
                                              && (stat.dup || stat.new_out))) begin
                    status_next = lsmt_pkg::ST_INVARIANT;
                end else begin
                    cmd.shift_start = 1'b1;
                    state_next      = lsmt_pkg::S_SHIFT;
                end
            end
            lsmt_pkg::S_SHIFT: begin
                cmd.step = !stat.eng_done;
                if (stat.eng_done && !stat.pipe_busy) begin
                    state_next = lsmt_pkg::S_PLACE;
                end
            end
            lsmt_pkg::S_PLACE: begin
                status_next = lsmt_pkg::ST_OK;
                state_next  = lsmt_pkg::S_FINISH;
                if (stat.cmd == lsmt_pkg::CMD_REMOVE) begin
                    cmd.cnt_dec = 1'b1;
                end else begin
                    cmd.wr_place = 1'b1;
                    cmd.cnt_inc  = (stat.cmd == lsmt_pkg::CMD_ADD);
                end
            end
            lsmt_pkg::S_FINISH: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = lsmt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = lsmt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/lsmt_dp.sv
// Datapath: item registers, range registers, table memory, scan/shift engine, reply.
// Depends on lsmt_pkg and lsmt_ram.
`timescale 1ns / 1ps

module lsmt_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lsmt_pkg::ctrl_cmd_t               cmd,
    output lsmt_pkg::dp_stat_t                stat,
    // item fields
    input  lsmt_pkg::cmd_t                    in_cmd,
    input  logic [lsmt_pkg::IDX_W-1:0]        in_index,
    input  logic [lsmt_pkg::POS_W-1:0]        in_position,
    input  logic [lsmt_pkg::CONF_W-1:0]       in_confidence,
    input  logic                              in_lock,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsmt_pkg::POS_W-1:0]        cfg_data,
    // reply
    output logic                              out_valid,
    input  logic                              out_ready,
    output lsmt_pkg::st_t                     out_status,
    output logic [lsmt_pkg::CNT_W-1:0]        out_count,
    output logic [lsmt_pkg::POS_W-1:0]        out_position,
    output logic [lsmt_pkg::CONF_W-1:0]       out_confidence,
    output logic                              out_locked
);

    localparam int AW = lsmt_pkg::ADDR_W;
    localparam int CW = lsmt_pkg::CNT_W;
    localparam int PW = lsmt_pkg::POS_W;
    localparam int FW = lsmt_pkg::CONF_W;
    localparam int WW = lsmt_pkg::WORD_W;
    localparam int W_CONF_HI = lsmt_pkg::W_LOCK - 1;

    // Latched item
    lsmt_pkg::cmd_t   cmd_reg;
    logic [lsmt_pkg::IDX_W-1:0] idx_reg;
    logic [PW-1:0]    pos_reg;
    logic [FW-1:0]    conf_reg;
    logic             lock_reg;

    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    range_start_reg, range_end_reg;

    // Engine
    logic [AW-1:0]    eng_ptr_reg;
    logic [CW-1:0]    eng_left_reg;
    logic             eng_down_reg;   // pointer counts down, writes go one up
    logic             eng_wr_reg;     // shift pass (writes) versus scan pass
    logic             pipe_vld_reg;
    logic [AW-1:0]    pipe_addr_reg;
    logic             fetch_d_reg;

    // Scan results
    logic             dup_reg, rng_bad_reg;
    logic [CW-1:0]    j_reg;

    // Fetched entry and read result
    logic [WW-1:0]    ent_reg;
    logic             read_ok_reg;

    // Reply registers
    logic             out_valid_reg;
    lsmt_pkg::st_t    out_status_reg;
    logic [CW-1:0]    out_count_reg;
    logic [WW-1:0]    out_word_reg;

    // Memory ports
    logic             rd_en, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [WW-1:0]    rd_data, wr_data;

    logic [AW-1:0]    idx_a;
    logic [CW-1:0]    idx_c;
    logic [CW-1:0]    cnt_m1;
    logic [PW-1:0]    rd_pos;
    logic             skip_hit;

    assign idx_a  = idx_reg[AW-1:0];
    assign idx_c  = CW'(idx_a);
    assign cnt_m1 = count_reg - CW'(1);
    assign rd_pos = rd_data[PW-1:0];

    // Entry being moved or removed is left out of the scan
    assign skip_hit = (cmd_reg != lsmt_pkg::CMD_ADD) && (pipe_addr_reg == idx_a);

    lsmt_ram #(
        .WIDTH(WW),
        .DEPTH(lsmt_pkg::MAX_MARKS)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Memory port selection
    always_comb begin
        rd_en   = cmd.fetch | cmd.step;
        rd_addr = cmd.fetch ? idx_a : eng_ptr_reg;
        wr_en   = 1'b0;
        wr_addr = idx_a;
        wr_data = {lock_reg, rd_data[W_CONF_HI:lsmt_pkg::W_CONF_LO], rd_pos};
        if (cmd.wr_lock) begin
            wr_en = 1'b1;
        end else if (cmd.wr_place) begin
            wr_en   = 1'b1;
            wr_addr = j_reg[AW-1:0];
            if (cmd_reg == lsmt_pkg::CMD_ADD) begin
                wr_data = {lock_reg, conf_reg, pos_reg};
            end else begin
                wr_data = {ent_reg[WW-1:PW], pos_reg};
            end
        end else if (pipe_vld_reg && eng_wr_reg) begin
            wr_en   = 1'b1;
            wr_addr = eng_down_reg ? pipe_addr_reg + AW'(1) : pipe_addr_reg - AW'(1);
            wr_data = rd_data;
        end
    end

    // Item and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_start_reg <= '0;
            range_end_reg   <= '1;
            count_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_index == lsmt_pkg::REG_RANGE_START) begin
                range_start_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == lsmt_pkg::REG_RANGE_END) begin
                range_end_reg <= cfg_data;
            end
            if (cmd.cnt_inc) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.cnt_dec) begin
                count_reg <= cnt_m1;
            end
        end
        if (cmd.take) begin
            cmd_reg  <= in_cmd;
            idx_reg  <= in_index;
            pos_reg  <= in_position;
            conf_reg <= in_confidence;
            lock_reg <= in_lock;
        end
    end

    assign cfg_ready = 1'b1;

    // Scan and shift engine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_vld_reg <= 1'b0;
            fetch_d_reg  <= 1'b0;
            eng_left_reg <= '0;
            read_ok_reg  <= 1'b0;
        end else begin
            pipe_vld_reg <= cmd.step;
            fetch_d_reg  <= cmd.fetch;
            if (cmd.take) begin
                read_ok_reg <= 1'b0;
            end else if (cmd.keep_read) begin
                read_ok_reg <= 1'b1;
            end
            if (cmd.scan_start) begin
                eng_ptr_reg  <= '0;
                eng_left_reg <= count_reg;
                eng_down_reg <= 1'b0;
                eng_wr_reg   <= 1'b0;
            end else if (cmd.shift_start) begin
                eng_wr_reg <= 1'b1;
                if (cmd_reg == lsmt_pkg::CMD_ADD) begin
                    eng_down_reg <= 1'b1;
                    eng_ptr_reg  <= cnt_m1[AW-1:0];
                    eng_left_reg <= count_reg - j_reg;
                end else if (cmd_reg == lsmt_pkg::CMD_REMOVE) begin
                    eng_down_reg <= 1'b0;
                    eng_ptr_reg  <= idx_a + AW'(1);
                    eng_left_reg <= cnt_m1 - idx_c;
                end else if (j_reg > idx_c) begin
                    eng_down_reg <= 1'b0;
                    eng_ptr_reg  <= idx_a + AW'(1);
                    eng_left_reg <= j_reg - idx_c;
                end else begin
                    eng_down_reg <= 1'b1;
                    eng_ptr_reg  <= idx_a - AW'(1);
                    eng_left_reg <= idx_c - j_reg;
                end
            end else if (cmd.step) begin
                eng_ptr_reg  <= eng_down_reg ? eng_ptr_reg - AW'(1) : eng_ptr_reg + AW'(1);
                eng_left_reg <= eng_left_reg - CW'(1);
            end
        end
        pipe_addr_reg <= eng_ptr_reg;
        if (fetch_d_reg) begin
            ent_reg <= rd_data;
        end
    end

    // Scan accumulation: duplicates, insertion slot, range check
    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            dup_reg     <= 1'b0;
            rng_bad_reg <= 1'b0;
            j_reg       <= '0;
        end else if (pipe_vld_reg && !eng_wr_reg && !skip_hit) begin
            if (rd_pos == pos_reg) begin
                dup_reg <= 1'b1;
            end
            if (rd_pos <= pos_reg) begin
                j_reg <= j_reg + CW'(1);
            end
            if (rd_pos < range_start_reg || rd_pos >= range_end_reg) begin
                rng_bad_reg <= 1'b1;
            end
        end
    end

    // Reply register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            out_status_reg <= cmd.status;
            out_count_reg  <= count_reg;
            out_word_reg   <= read_ok_reg ? ent_reg : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_count      = out_count_reg;
    assign out_position   = out_word_reg[PW-1:0];
    assign out_confidence = out_word_reg[W_CONF_HI:lsmt_pkg::W_CONF_LO];
    assign out_locked     = out_word_reg[lsmt_pkg::W_LOCK];

    // Status toward the controller
    always_comb begin
        stat           = '0;
        stat.cmd       = cmd_reg;
        stat.idx_bad   = idx_reg >= lsmt_pkg::IDX_W'(count_reg);
        stat.conf_bad  = conf_reg > lsmt_pkg::CONF_ONE;
        stat.full      = count_reg >= CW'(lsmt_pkg::MAX_MARKS);
        stat.at_min    = count_reg <= lsmt_pkg::MIN_KEEP;
        stat.locked    = rd_data[lsmt_pkg::W_LOCK];
        stat.eng_done  = (eng_left_reg == '0);
        stat.pipe_busy = pipe_vld_reg;
        stat.dup       = dup_reg;
        stat.rng_bad   = rng_bad_reg;
        stat.range_inv = range_end_reg <= range_start_reg;
        stat.new_out   = pos_reg < range_start_reg || pos_reg >= range_end_reg;
        stat.out_free  = !out_valid_reg || out_ready;
    end

endmodule

// File: rtl/locked_sorted_mark_table_core.sv
// Read and set lock go through decode and an entry fetch before the reply; add, move
// and remove go on to a scan pass over the stored entries, an evaluate step, a shift
// pass that reads and rewrites each moved entry, and a place step (add skips the fetch).
// One item is worked on at a time; the next is accepted when the reply is registered.
// Reset (aresetn, synchronous, active low) empties the table and restores the range;
// table memory contents are not cleared, entries past the count are never read.
`timescale 1ns / 1ps

module locked_sorted_mark_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // entry_index, mark_position, mark_confidence, lock_flag
    input  logic [2:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // entry_count, read_position, read_confidence, read_locked
    output logic [2:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    lsmt_pkg::ctrl_cmd_t ctl;
    lsmt_pkg::dp_stat_t  stat;
    logic [8:0]          entry_count;
    logic [31:0]         read_position;
    logic [16:0]         read_confidence;
    logic                read_locked;

    lsmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (ctl)
    );

    lsmt_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (ctl),
        .stat          (stat),
        .in_cmd        (s_tuser),
        .in_index      (s_tdata[15:0]),
        .in_position   (s_tdata[47:16]),
        .in_confidence (s_tdata[64:48]),
        .in_lock       (s_tdata[65]),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (m_tuser),
        .out_count     (entry_count),
        .out_position  (read_position),
        .out_confidence(read_confidence),
        .out_locked    (read_locked)
    );

    assign m_tdata = {5'd0, read_locked, read_confidence, read_position, entry_count};

    // One item in flight: accepting blocks the input until the reply is loaded
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // Count never exceeds table capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:0] <= 9'(lsmt_pkg::MAX_MARKS)))
        else $error("entry count beyond capacity");

    // Read fields are zero unless the reply is a good status
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != lsmt_pkg::ST_OK) |-> (m_tdata[58:9] == '0))
        else $error("read fields set on a failed command");

    // A new reply appears only after the input side has gone busy
    a_reply_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("reply without an item");

endmodule
